### hdl/assert_macros.svh
// Assertion macros for the RTL of the colour conversion block, used by its top level.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RHX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define RHX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/rgbhsvxy_pkg.sv
// Types, constants and the sRGB linearisation table for the RGB to HSV / CIE xy block.
// No dependencies.
package rgbhsvxy_pkg;

    localparam int XY_FRAC_BITS_DEF  = 16;
    localparam int SAT_FRAC_BITS_DEF = 12;

    localparam int LIN_W  = 25;     // Q0.24, 1.0 needs the extra bit
    localparam int COEF_W = 21;     // coefficients in millionths
    localparam int XYZ_W  = 46;     // products and sums of XYZ
    localparam int HUE_QB = 9;      // hue quotient bits, quotient <= 420
    localparam int HUE_NW = 17;     // hue numerator bits

    localparam logic [12:0] SAT_MAX    = 13'h1FFF;
    localparam logic [15:0] CHROMA_MAX = 16'hFFFF;
    localparam logic [8:0]  DEG_360    = 9'd360;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [8:0]  hue_deg;
        logic [12:0] saturation;
        logic [7:0]  value_level;
        logic [15:0] chroma_x;
        logic [15:0] chroma_y;
        logic        black_flag;
    } t_pix_out;

    typedef enum logic [1:0] {
        SEC_RED = 2'd0,
        SEC_GRN = 2'd1,
        SEC_BLU = 2'd2
    } t_sector;

    typedef logic [COEF_W-1:0] t_coef_row [3];
    typedef t_coef_row t_coef_mat [3];

    localparam t_coef_mat COEF = '{
        '{21'd649926, 21'd103455, 21'd197109},
        '{21'd234327, 21'd743075, 21'd22598},
        '{21'd0,      21'd53077,  21'd1035763}
    };

    typedef logic [LIN_W-1:0] t_lin_tab [256];

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] q30_pow5(input logic [63:0] u);
        logic [63:0] p;
        p = u;
        for (int i = 0; i < 4; i++) begin
            p = q30_mul(p, u);
        end
        return p;
    endfunction

    // One table entry: linear segment below code 11, power curve from code 11 up.
    function automatic logic [LIN_W-1:0] lin_entry(input int c);
        logic [63:0] num;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (c <= 10) begin
            num = 64'(c) * 64'd100 * (64'd1 << 24) + 64'd164730;
            return LIN_W'(num / 64'd329460);
        end
        t  = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
        t2 = q30_mul(t, t);
        lo = 64'd0;
        hi = 64'd1 << 30;
        for (int i = 0; i < 40; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (q30_pow5(mid) <= t2) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return LIN_W'((q30_mul(t2, lo) + 64'd32) >> 6);
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = lin_entry(c);
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

endpackage

### hdl/rgb_to_hsv_and_cie_xy_top.sv
// RGB pixel to HSV and CIE xy converter, top level.
// Depends on rgbhsvxy_pkg, rgbhsvxy_div and assert_macros.svh.
//
// One 8-bit RGB pixel in, one result out per transfer: hue in whole degrees,
// saturation in Q1.SAT_FRAC_BITS, value as the largest byte, and CIE x/y in
// Q0.XY_FRAC_BITS (clipped to 16 bits) with a flag for a black XYZ sum.
// Throughput is one pixel per clock while the skid slot is empty. The pipeline depth
// is set by the bit-per-stage dividers for x and y, through DIVS = max(9,
// SAT_FRAC_BITS + 1, XY_FRAC_BITS + 1). A two-entry output buffer (output register
// plus skid) lets the pipeline keep taking pixels while one result waits.
`include "assert_macros.svh"

module rgb_to_hsv_and_cie_xy_top #(
    parameter int XY_FRAC_BITS  = rgbhsvxy_pkg::XY_FRAC_BITS_DEF,
    parameter int SAT_FRAC_BITS = rgbhsvxy_pkg::SAT_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  rgbhsvxy_pkg::t_pix_in  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output rgbhsvxy_pkg::t_pix_out o_out_data
);

    localparam int SAT_QB = SAT_FRAC_BITS + 1;
    localparam int XY_QB  = XY_FRAC_BITS + 1;
    localparam int SAT_NW = SAT_FRAC_BITS + 8;
    localparam int DIVS_A = (SAT_QB > rgbhsvxy_pkg::HUE_QB) ? SAT_QB : rgbhsvxy_pkg::HUE_QB;
    localparam int DIVS   = (XY_QB > DIVS_A) ? XY_QB : DIVS_A;
    // Stages: 1 lookup/max, 2 products, 3 XYZ, 4 sum, 5..4+DIVS divide, N final.
    localparam int N      = DIVS + 5;
    localparam int XYW    = rgbhsvxy_pkg::XYZ_W;
    localparam int LW     = rgbhsvxy_pkg::LIN_W;

    // Pipeline advances whenever the skid slot is empty.
    logic ce;
    logic r_v [1:N];

    // ---------------- stage 1: max/min, sector, table lookups
    rgbhsvxy_pkg::t_sector n_sec;
    logic [7:0] n_mx;
    logic [7:0] n_mn;
    rgbhsvxy_pkg::t_pix_in r_pix;
    rgbhsvxy_pkg::t_sector r_sec;
    logic [7:0]    r_dl1;
    logic [LW-1:0] r_lin [3];
    logic [7:0]    r_mx  [1:N-1];
    logic          r_dnz [1:N-1];

    always_comb begin
        if (i_in_data.red_in >= i_in_data.green_in && i_in_data.red_in >= i_in_data.blue_in) begin
            n_sec = rgbhsvxy_pkg::SEC_RED;
            n_mx  = i_in_data.red_in;
        end else if (i_in_data.green_in >= i_in_data.red_in
                     && i_in_data.green_in >= i_in_data.blue_in) begin
            n_sec = rgbhsvxy_pkg::SEC_GRN;
            n_mx  = i_in_data.green_in;
        end else begin
            n_sec = rgbhsvxy_pkg::SEC_BLU;
            n_mx  = i_in_data.blue_in;
        end
        n_mn = i_in_data.red_in;
        if (i_in_data.green_in < n_mn) begin
            n_mn = i_in_data.green_in;
        end
        if (i_in_data.blue_in < n_mn) begin
            n_mn = i_in_data.blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pix    <= i_in_data;
            r_sec    <= n_sec;
            r_dl1    <= n_mx - n_mn;
            r_mx[1]  <= n_mx;
            r_dnz[1] <= (n_mx != n_mn);
            r_lin[0] <= rgbhsvxy_pkg::LIN_TAB[i_in_data.red_in];
            r_lin[1] <= rgbhsvxy_pkg::LIN_TAB[i_in_data.green_in];
            r_lin[2] <= rgbhsvxy_pkg::LIN_TAB[i_in_data.blue_in];
        end
    end

    // Side data carried alongside to the final stage.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 2; k <= N - 1; k++) begin
                r_mx[k]  <= r_mx[k-1];
                r_dnz[k] <= r_dnz[k-1];
            end
        end
    end

    // ---------------- stage 2: matrix products, hue and saturation numerators
    logic [rgbhsvxy_pkg::HUE_NW-1:0] n_hnum;
    logic [rgbhsvxy_pkg::HUE_NW-1:0] w_r60;
    logic [rgbhsvxy_pkg::HUE_NW-1:0] w_g60;
    logic [rgbhsvxy_pkg::HUE_NW-1:0] w_b60;
    logic [rgbhsvxy_pkg::HUE_NW-1:0] w_d60;
    logic [SAT_NW-1:0] n_snum;
    logic [XYW-1:0] r_prod [3][3];
    logic [7:0] r_hrem;
    logic [rgbhsvxy_pkg::HUE_QB-1:0] r_hbits;
    logic [7:0] r_hden;
    logic [7:0] r_srem;
    logic [SAT_QB-1:0] r_sbits;

    assign w_r60 = rgbhsvxy_pkg::HUE_NW'(r_pix.red_in) * 17'd60;
    assign w_g60 = rgbhsvxy_pkg::HUE_NW'(r_pix.green_in) * 17'd60;
    assign w_b60 = rgbhsvxy_pkg::HUE_NW'(r_pix.blue_in) * 17'd60;
    assign w_d60 = rgbhsvxy_pkg::HUE_NW'(r_dl1) * 17'd60;

    always_comb begin
        unique case (r_sec)
            rgbhsvxy_pkg::SEC_RED: n_hnum = w_g60 + w_d60 * 17'd6 - w_b60;
            rgbhsvxy_pkg::SEC_GRN: n_hnum = w_b60 + w_d60 * 17'd2 - w_r60;
            default:               n_hnum = w_r60 + w_d60 * 17'd4 - w_g60;
        endcase
        n_snum = {r_dl1, SAT_FRAC_BITS'(0)} + SAT_NW'(r_mx[1] >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= XYW'(r_lin[j]) * XYW'(rgbhsvxy_pkg::COEF[i][j]);
                end
            end
            r_hrem  <= n_hnum[rgbhsvxy_pkg::HUE_NW-1:rgbhsvxy_pkg::HUE_QB];
            r_hbits <= n_hnum[rgbhsvxy_pkg::HUE_QB-1:0];
            r_hden  <= r_dl1;
            r_srem  <= 8'(n_snum >> SAT_QB);
            r_sbits <= n_snum[SAT_QB-1:0];
        end
    end

    // ---------------- stage 3: X, Y, Z
    logic [XYW-1:0] r_x3;
    logic [XYW-1:0] r_y3;
    logic [XYW-1:0] r_z3;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x3 <= r_prod[0][0] + r_prod[0][1] + r_prod[0][2];
            r_y3 <= r_prod[1][0] + r_prod[1][1] + r_prod[1][2];
            r_z3 <= r_prod[2][0] + r_prod[2][1] + r_prod[2][2];
        end
    end

    // ---------------- stage 4: S = X+Y+Z; X and Y are below S whenever S is non-zero
    logic [XYW-1:0] n_sum;
    logic [XYW-1:0] r_x4;
    logic [XYW-1:0] r_y4;
    logic [XYW-1:0] r_s4;
    logic           r_sz [4:N-1];

    assign n_sum = r_x3 + r_y3 + r_z3;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x4  <= r_x3;
            r_y4  <= r_y3;
            r_s4  <= n_sum;
            r_sz[4] <= (n_sum == '0);
            for (int k = 5; k <= N - 1; k++) begin
                r_sz[k] <= r_sz[k-1];
            end
        end
    end

    // ---------------- dividers, all ending at stage N-1
    logic [rgbhsvxy_pkg::HUE_QB-1:0] w_hq;
    logic [SAT_QB-1:0] w_sq;
    logic [XY_QB-1:0]  w_xq;
    logic [XY_QB-1:0]  w_yq;

    rgbhsvxy_div #(
        .DW(8), .QB(rgbhsvxy_pkg::HUE_QB), .STAGES(DIVS + 2)
    ) u_hue_div (
        .i_clk(i_clk), .i_en(ce), .i_rem(r_hrem), .i_den(r_hden),
        .i_bits(r_hbits), .o_quo(w_hq)
    );

    rgbhsvxy_div #(
        .DW(8), .QB(SAT_QB), .STAGES(DIVS + 2)
    ) u_sat_div (
        .i_clk(i_clk), .i_en(ce), .i_rem(r_srem), .i_den(r_mx[2]),
        .i_bits(r_sbits), .o_quo(w_sq)
    );

    rgbhsvxy_div #(
        .DW(XYW), .QB(XY_QB), .STAGES(DIVS)
    ) u_x_div (
        .i_clk(i_clk), .i_en(ce), .i_rem(r_x4), .i_den(r_s4),
        .i_bits('0), .o_quo(w_xq)
    );

    rgbhsvxy_div #(
        .DW(XYW), .QB(XY_QB), .STAGES(DIVS)
    ) u_y_div (
        .i_clk(i_clk), .i_en(ce), .i_rem(r_y4), .i_den(r_s4),
        .i_bits('0), .o_quo(w_yq)
    );

    // ---------------- stage N: wrap hue, round and clip
    rgbhsvxy_pkg::t_pix_out n_fin;
    rgbhsvxy_pkg::t_pix_out r_fin;
    logic [XY_QB:0] w_xr;
    logic [XY_QB:0] w_yr;
    logic [31:0]    w_s32;
    logic [31:0]    w_x32;
    logic [31:0]    w_y32;

    assign w_xr  = {1'b0, w_xq} + (XY_QB + 1)'(1);
    assign w_yr  = {1'b0, w_yq} + (XY_QB + 1)'(1);
    assign w_s32 = 32'(w_sq);
    assign w_x32 = 32'(w_xr[XY_QB:1]);
    assign w_y32 = 32'(w_yr[XY_QB:1]);

    always_comb begin
        n_fin = '0;
        if (r_dnz[N-1]) begin
            n_fin.hue_deg = (w_hq >= rgbhsvxy_pkg::DEG_360) ? w_hq - rgbhsvxy_pkg::DEG_360 : w_hq;
        end
        if (r_mx[N-1] != 8'd0) begin
            n_fin.saturation = (w_s32 > 32'(rgbhsvxy_pkg::SAT_MAX)) ? rgbhsvxy_pkg::SAT_MAX
                                                                     : w_s32[12:0];
        end
        n_fin.value_level = r_mx[N-1];
        if (r_sz[N-1]) begin
            n_fin.black_flag = 1'b1;
        end else begin
            n_fin.chroma_x = (w_x32 > 32'(rgbhsvxy_pkg::CHROMA_MAX)) ? rgbhsvxy_pkg::CHROMA_MAX
                                                                      : w_x32[15:0];
            n_fin.chroma_y = (w_y32 > 32'(rgbhsvxy_pkg::CHROMA_MAX)) ? rgbhsvxy_pkg::CHROMA_MAX
                                                                      : w_y32[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_fin <= n_fin;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (ce) begin
            r_v[1] <= i_in_valid;
            for (int k = 2; k <= N; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------- output register and skid slot
    rgbhsvxy_pkg::t_pix_out r_o;
    rgbhsvxy_pkg::t_pix_out r_sk;
    logic r_o_v;
    logic r_sk_v;
    logic w_out_free;

    assign ce         = !r_sk_v;
    assign w_out_free = !r_o_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (w_out_free) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end
        end else if (w_out_free) begin
            r_o_v <= r_v[N];
        end else if (r_v[N]) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (w_out_free) begin
                r_o <= r_sk;
            end
        end else if (w_out_free) begin
            r_o <= r_fin;
        end else begin
            r_sk <= r_fin;
        end
    end

    assign o_in_ready  = ce;
    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o;

    // ---------------- checks
    `RHX_ASSERT_IMP(a_skid_behind_out, r_sk_v, r_o_v)
    `RHX_ASSERT_NXT(a_stalled_result_kept, r_v[N] && !r_sk_v && r_o_v && !i_out_ready, r_sk_v)
    `RHX_ASSERT_IMP(a_hue_range, r_o_v, r_o.hue_deg < rgbhsvxy_pkg::DEG_360)
    `RHX_ASSERT_IMP(a_black_zero_xy, r_o_v && r_o.black_flag,
                    r_o.chroma_x == 16'd0 && r_o.chroma_y == 16'd0)

endmodule

### hdl/rgbhsvxy_div.sv
// Pipelined restoring divider, one quotient bit per stage, with leading delay stages.
// No package dependencies.
module rgbhsvxy_div #(
    parameter int DW     = 8,
    parameter int QB     = 9,
    parameter int STAGES = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,    // must be below i_den
    input  logic [DW-1:0] i_den,
    input  logic [QB-1:0] i_bits,   // numerator bits still to bring down, MSB first
    output logic [QB-1:0] o_quo
);

    localparam int SKIP = STAGES - QB;

    logic [DW-1:0] r_rem [STAGES];
    logic [DW-1:0] r_den [STAGES];
    logic [QB-1:0] r_bq  [STAGES];
    logic [DW-1:0] n_rem [STAGES];
    logic [QB-1:0] n_bq  [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic [DW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [QB-1:0] s_bq;
        logic [DW:0]   s_t;

        if (j == 0) begin : g_first
            assign s_rem = i_rem;
            assign s_den = i_den;
            assign s_bq  = i_bits;
        end else begin : g_next
            assign s_rem = r_rem[j-1];
            assign s_den = r_den[j-1];
            assign s_bq  = r_bq[j-1];
        end

        assign s_t = {s_rem, s_bq[QB-1]};

        always_comb begin
            if (j >= SKIP) begin
                if (s_t >= {1'b0, s_den}) begin
                    n_rem[j] = DW'(s_t - {1'b0, s_den});
                    n_bq[j]  = {s_bq[QB-2:0], 1'b1};
                end else begin
                    n_rem[j] = s_t[DW-1:0];
                    n_bq[j]  = {s_bq[QB-2:0], 1'b0};
                end
            end else begin
                n_rem[j] = s_rem;
                n_bq[j]  = s_bq;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= s_den;
                r_bq[j]  <= n_bq[j];
            end
        end
    end

    assign o_quo = r_bq[STAGES-1];

endmodule

### tb/sv/tb_pixel_checker.sv
// Checker for the RGB to HSV / CIE xy converter: watches both channels,
// predicts each result and compares it field by field. Depends on rgbhsvxy_pkg.
module tb_pixel_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  rgbhsvxy_pkg::t_pix_in  i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  rgbhsvxy_pkg::t_pix_out i_out_data,
    output int                     o_err_cnt,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int XYB = 16;
    localparam int SATB = 12;

    logic [24:0]            srgb_lin [256];
    rgbhsvxy_pkg::t_pix_out pixel_q [$];

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] fx_fifth(input logic [63:0] u);
        logic [63:0] p;
        p = u;
        for (int i = 0; i < 4; i++) p = fx_mul(p, u);
        return p;
    endfunction

    function automatic logic [24:0] srgb_decode(input int c);
        logic [63:0] t, t2, lo, hi, mid;
        if (c <= 10)
            return 25'((64'(c) * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460);
        t  = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
        t2 = fx_mul(t, t);
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (fx_fifth(mid) <= t2) lo = mid;
            else hi = mid - 64'd1;
        end
        return 25'((fx_mul(t2, lo) + 64'd32) >> 6);
    endfunction

    // round half up of num*2^bits/den, num <= den
    function automatic logic [63:0] ratio_q(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, r;
        q = (num >= den) ? 64'd1 : 64'd0;
        r = num - q * den;
        for (int i = 0; i < XYB + 1; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    function automatic rgbhsvxy_pkg::t_pix_out convert_pixel(input rgbhsvxy_pkg::t_pix_in px);
        rgbhsvxy_pkg::t_pix_out o;
        logic [63:0] r, g, b, mx, mn, dl, num, sat, s, cx, cy;
        logic [63:0] ln [3];
        logic [63:0] xyz [3];
        logic [63:0] cm [3][3];
        cm = '{'{649926, 103455, 197109}, '{234327, 743075, 22598},
               '{0, 53077, 1035763}};
        r = px.red_in; g = px.green_in; b = px.blue_in;
        o = '0;
        if (r >= g && r >= b) mx = r;
        else if (g >= b) mx = g;
        else mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        if (dl != 0) begin
            if (mx == r) num = 60 * g + 360 * dl - 60 * b;
            else if (mx == g) num = 60 * b + 120 * dl - 60 * r;
            else num = 60 * r + 240 * dl - 60 * g;
            o.hue_deg = 9'((num / dl) % 360);
        end
        if (mx != 0) begin
            sat = ((dl << SATB) + mx / 2) / mx;
            o.saturation = (sat > 8191) ? 13'h1FFF : 13'(sat);
        end
        o.value_level = 8'(mx);
        ln[0] = srgb_lin[r]; ln[1] = srgb_lin[g]; ln[2] = srgb_lin[b];
        for (int i = 0; i < 3; i++) begin
            xyz[i] = 0;
            for (int j = 0; j < 3; j++) xyz[i] += ln[j] * cm[i][j];
        end
        s = xyz[0] + xyz[1] + xyz[2];
        if (s == 0) o.black_flag = 1'b1;
        else begin
            cx = ratio_q(xyz[0], s);
            cy = ratio_q(xyz[1], s);
            o.chroma_x = (cx > 65535) ? 16'hFFFF : 16'(cx);
            o.chroma_y = (cy > 65535) ? 16'hFFFF : 16'(cy);
        end
        return o;
    endfunction

    initial begin
        o_err_cnt = 0;
        for (int c = 0; c < 256; c++) srgb_lin[c] = srgb_decode(c);
    end

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        rgbhsvxy_pkg::t_pix_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) pixel_q.push_back(convert_pixel(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %p", $time, i_out_data);
                    o_err_cnt++;
                end else begin
                    want = pixel_q.pop_front();
                    if (want.hue_deg !== i_out_data.hue_deg ||
                        want.saturation !== i_out_data.saturation ||
                        want.value_level !== i_out_data.value_level ||
                        want.chroma_x !== i_out_data.chroma_x ||
                        want.chroma_y !== i_out_data.chroma_y ||
                        want.black_flag !== i_out_data.black_flag) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, want, i_out_data);
                        o_err_cnt++;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb_top.sv
// Top of the colour converter testbench: clock, reset, pixel stimulus and verdict.
// Depends on rgbhsvxy_pkg, rgb_to_hsv_and_cie_xy_top and tb_pixel_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;   // pipeline is 23 deep at defaults

    logic     clk, rst_n;
    logic     in_valid, in_ready, out_valid, out_ready;
    rgbhsvxy_pkg::t_pix_in  in_data;
    rgbhsvxy_pkg::t_pix_out out_data;
    int       err_cnt, pending;
    int       idle_cycles;
    bit       calm;             // stretch with no idling on either side

    rgb_to_hsv_and_cie_xy_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    tb_pixel_checker i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_err_cnt(err_cnt), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls about 9% of cycles, except during the calm stretch.
    initial out_ready = 1'b0;
    always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 9);

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one pixel, hold it until the transfer, with a random gap first.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{red_in: r, green_in: g, blue_in: b};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    logic [7:0] base, r, g, b;
    initial begin
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: black, white, greys, primaries, secondaries, ties, linear knee.
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(128, 128, 128);
        send_pixel(1, 1, 1);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);
        send_pixel(255, 0, 1);      // hue just under 360
        send_pixel(1, 0, 0);
        send_pixel(0, 0, 1);
        send_pixel(10, 11, 10);     // either side of the linear segment
        send_pixel(200, 200, 100);  // red/green tie for max
        send_pixel(100, 200, 200);  // green/blue tie
        send_pixel(200, 100, 200);  // red/blue tie
        send_pixel(255, 254, 0);
        send_pixel(3, 2, 1);
        send_pixel(170, 85, 0);

        // Sender holds off until every result is back.
        pause_until_drained();

        for (int n = 0; n < 1850; n++) begin
            calm = (n >= 700 && n < 1000);
            case ($urandom_range(3))
                0: begin    // near-grey pixels
                    base = 8'($urandom_range(255));
                    r = base ^ 8'($urandom_range(3));
                    g = base ^ 8'($urandom_range(3));
                    b = base ^ 8'($urandom_range(3));
                end
                1: begin    // low codes around the linear knee
                    r = 8'($urandom_range(20));
                    g = 8'($urandom_range(20));
                    b = 8'($urandom_range(20));
                end
                default: begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
            endcase
            send_pixel(r, g, b);
            if (n == 1200) pause_until_drained();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### rgb_to_hsv_and_cie_xy_top.f
+incdir+hdl
hdl/rgbhsvxy_pkg.sv
hdl/rgbhsvxy_div.sv
hdl/rgb_to_hsv_and_cie_xy_top.sv
tb/sv/tb_pixel_checker.sv
tb/sv/tb_top.sv
